>>> rtl/urb_pkg.sv
// ----------------------------------------------------------------------------
// UART register block package
// Shared payload types, FIFO control bundle and register map constants.
// ----------------------------------------------------------------------------
`default_nettype none

package urb_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        opcode;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } out_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctrl_t;

  // Register offsets.
  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_IER  = 3'd1;
  localparam logic [2:0] REG_IIR  = 3'd2;
  localparam logic [2:0] REG_LCR  = 3'd3;
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam logic [2:0] REG_LSR  = 3'd5;
  localparam logic [2:0] REG_MSR  = 3'd6;
  localparam logic [2:0] REG_SCR  = 3'd7;

  localparam int LCR_DLAB_BIT = 7;
  localparam int MCR_LOOP_BIT = 4;
  localparam int FCR_ENABLE_BIT = 0;
  localparam int FCR_RX_CLR_BIT = 1;
  localparam int FCR_TX_CLR_BIT = 2;

  localparam logic [7:0] IIR_FIFO_ON  = 8'hC1;
  localparam logic [7:0] IIR_FIFO_OFF = 8'h01;
  localparam logic [7:0] LSR_DR       = 8'h01;
  localparam logic [7:0] LSR_OE       = 8'h02;
  localparam logic [7:0] LSR_TX_EMPTY = 8'h60;

endpackage

`default_nettype wire

>>> rtl/uart_register_block_unit.sv
// ----------------------------------------------------------------------------
// UART register block
// 16550-style register file with receive and transmit FIFOs in memories.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one event per transfer: a bus read, a bus write,
//   a byte arriving from the line, or a transmit slot tick. Every event gives
//   exactly one result on the out_ channel: read data for a bus read, and a
//   byte with tx_valid set when a tick sends a byte to the line.
//   Events that touch only registers need no wait, so they can be taken
//   every cycle while the receiver does not stall. Events that pop a FIFO
//   (a data read with bytes waiting, or a tick with bytes to send) pass a
//   read state with no new event, as the FIFO memory output is registered.
//   The result sits in an output register; the next event is taken while
//   that result is being transferred. If the receiver stalls, the block
//   holds the result and takes no new event until it is transferred.
//   After reset FIFO counts and all registers but the result are zero;
//   FIFO memories are not cleared; entries are only read after being written.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_block_unit
  import urb_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_payload,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_payload
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic       pend_tick_r, pend_tick_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;
  logic [7:0] div_lo_r, div_lo_nxt;
  logic [7:0] div_hi_r, div_hi_nxt;
  logic [3:0] ier_r, ier_nxt;
  logic [7:0] lcr_r, lcr_nxt;
  logic [4:0] mcr_r, mcr_nxt;
  logic [7:0] scr_r, scr_nxt;
  logic       fifo_on_r, fifo_on_nxt;
  logic       overrun_r, overrun_nxt;

  fifo_ctrl_t    rx_ctrl, tx_ctrl;
  logic [7:0]    rx_wdata;
  logic [CW-1:0] rx_count, tx_count;
  logic          rx_full, tx_full;
  logic [7:0]    rx_rdata, tx_rdata;

  logic       accept;
  logic       dlab, loopback;
  logic [7:0] rd;
  logic       fifo_change;

  assign dlab     = lcr_r[LCR_DLAB_BIT];
  assign loopback = mcr_r[MCR_LOOP_BIT];
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    pend_tick_nxt = pend_tick_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    div_lo_nxt    = div_lo_r;
    div_hi_nxt    = div_hi_r;
    ier_nxt       = ier_r;
    lcr_nxt       = lcr_r;
    mcr_nxt       = mcr_r;
    scr_nxt       = scr_r;
    fifo_on_nxt   = fifo_on_r;
    overrun_nxt   = overrun_r;
    rx_ctrl       = '0;
    tx_ctrl       = '0;
    rx_wdata      = in_payload.line_byte;
    rd            = '0;
    fifo_change   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_payload.opcode)
            OP_READ: begin
              unique case (in_payload.reg_offset)
                REG_DATA: begin
                  if (dlab) begin
                    rd = div_lo_r;
                  end else if (rx_count != '0) begin
                    rx_ctrl.pop   = 1'b1;
                    pend_tick_nxt = 1'b0;
                    state_nxt     = ST_READ;
                  end
                end
                REG_IER: rd = dlab ? div_hi_r : {4'b0, ier_r};
                REG_IIR: rd = fifo_on_r ? IIR_FIFO_ON : IIR_FIFO_OFF;
                REG_LCR: rd = lcr_r;
                REG_MCR: rd = {3'b0, mcr_r};
                REG_LSR: begin
                  rd = ((rx_count != '0) ? LSR_DR : 8'h00)
                     | (overrun_r ? LSR_OE : 8'h00)
                     | ((tx_count == '0) ? LSR_TX_EMPTY : 8'h00);
                  overrun_nxt = 1'b0;
                end
                REG_MSR: begin
                  // Loopback feeds the modem outputs back as CTS, DSR, RI, DCD.
                  if (loopback) begin
                    rd = {mcr_r[3], mcr_r[2], mcr_r[0], mcr_r[1], 4'b0};
                  end
                end
                REG_SCR: rd = scr_r;
              endcase
            end
            OP_WRITE: begin
              unique case (in_payload.reg_offset) inside
                REG_DATA: begin
                  if (dlab) begin
                    div_lo_nxt = in_payload.write_data;
                  end else if (loopback) begin
                    rx_ctrl.push = 1'b1;
                    rx_wdata     = in_payload.write_data;
                    if (rx_full) begin
                      overrun_nxt = 1'b1;
                    end
                  end else begin
                    // A write to a full transmit FIFO is dropped.
                    tx_ctrl.push = !tx_full;
                  end
                end
                REG_IER: begin
                  if (dlab) begin
                    div_hi_nxt = in_payload.write_data;
                  end else begin
                    ier_nxt = in_payload.write_data[3:0];
                  end
                end
                REG_IIR: begin
                  fifo_change = in_payload.write_data[FCR_ENABLE_BIT] != fifo_on_r;
                  fifo_on_nxt = in_payload.write_data[FCR_ENABLE_BIT];
                  rx_ctrl.clear = fifo_change || in_payload.write_data[FCR_RX_CLR_BIT];
                  tx_ctrl.clear = fifo_change || in_payload.write_data[FCR_TX_CLR_BIT];
                end
                REG_LCR: lcr_nxt = in_payload.write_data;
                REG_MCR: mcr_nxt = in_payload.write_data[4:0];
                REG_LSR, REG_MSR: ;
                REG_SCR: scr_nxt = in_payload.write_data;
              endcase
            end
            OP_LINE: begin
              if (!loopback) begin
                rx_ctrl.push = 1'b1;
                if (rx_full) begin
                  overrun_nxt = 1'b1;
                end
              end
            end
            default: begin
              if (tx_count != '0) begin
                tx_ctrl.pop   = 1'b1;
                pend_tick_nxt = 1'b1;
                state_nxt     = ST_READ;
              end
            end
          endcase
          if (state_nxt == ST_IDLE) begin
            out_valid_nxt     = 1'b1;
            out_nxt.read_data = rd;
            out_nxt.tx_valid  = 1'b0;
            out_nxt.tx_byte   = '0;
          end
        end
      end
      ST_READ: begin
        // The memory word popped in the previous cycle is available now.
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        out_nxt       = '0;
        if (!pend_tick_r) begin
          out_nxt.read_data = rx_rdata;
        end else if (loopback) begin
          rx_ctrl.push = 1'b1;
          rx_wdata     = tx_rdata;
          if (rx_full) begin
            overrun_nxt = 1'b1;
          end
        end else begin
          out_nxt.tx_valid = 1'b1;
          out_nxt.tx_byte  = tx_rdata;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_tick_r <= 1'b0;
      out_valid_r <= 1'b0;
      div_lo_r    <= '0;
      div_hi_r    <= '0;
      ier_r       <= '0;
      lcr_r       <= '0;
      mcr_r       <= '0;
      scr_r       <= '0;
      fifo_on_r   <= 1'b0;
      overrun_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_tick_r <= pend_tick_nxt;
      out_valid_r <= out_valid_nxt;
      div_lo_r    <= div_lo_nxt;
      div_hi_r    <= div_hi_nxt;
      ier_r       <= ier_nxt;
      lcr_r       <= lcr_nxt;
      mcr_r       <= mcr_nxt;
      scr_r       <= scr_nxt;
      fifo_on_r   <= fifo_on_nxt;
      overrun_r   <= overrun_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  urb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_rx_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rx_ctrl),
    .cap_one (!fifo_on_r),
    .wr_data (rx_wdata),
    .count   (rx_count),
    .full    (rx_full),
    .rd_data (rx_rdata)
  );

  urb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_tx_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (tx_ctrl),
    .cap_one (!fifo_on_r),
    .wr_data (in_payload.write_data),
    .count   (tx_count),
    .full    (tx_full),
    .rd_data (tx_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

>>> rtl/urb_fifo.sv
// ----------------------------------------------------------------------------
// UART FIFO
// Circular byte store in a synchronous memory with head pointer and fill
// count. Capacity drops to one entry when the FIFOs are switched off.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_fifo
  import urb_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fifo_ctrl_t    ctrl,
  input  wire logic          cap_one,
  input  wire logic [7:0]    wr_data,
  output logic      [CW-1:0] count,
  output logic               full,
  output logic      [7:0]    rd_data
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW:0]   head_inc;
  logic [7:0]    rd_data_r;

  assign full = cap_one ? (count_r != '0) : (count_r == CW'(DEPTH));

  // Head plus count stays below twice the depth, so one subtract wraps it.
  always_comb begin
    tail_sum = {{(CW + 1 - AW){1'b0}}, head_r} + {1'b0, count_r};
    if (tail_sum >= (CW + 1)'(DEPTH)) begin
      tail = AW'(tail_sum - (CW + 1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
    head_inc = {1'b0, head_r} + (AW + 1)'(1);
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (ctrl.pop) begin
      head_nxt  = (head_inc == (AW + 1)'(DEPTH)) ? '0 : AW'(head_inc);
      count_nxt = count_r - CW'(1);
    end else if (ctrl.push && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !full && !ctrl.clear) begin
      mem[tail] <= wr_data;
    end
    if (ctrl.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign count   = count_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/urb_checker.sv
// ----------------------------------------------------------------------------
// UART register block checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urb_checker
  import urb_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_payload
);

  // A stalled result keeps its valid and its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // A byte toward the line never comes with read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.tx_valid |-> out_payload.read_data == 8'h00)
    else $error("read data on a transmit result");

  // Without a transmitted byte the byte field is zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.tx_valid |-> out_payload.tx_byte == 8'h00)
    else $error("stray transmit byte");

  // Reset empties the result register.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_register_block_unit urb_checker u_urb_checker (.*);

`default_nettype wire
